@@ rtl/core/hbs_pkg.sv @@
// hbs_pkg: shared types, widths, register and mode codes for the height map sampler
// depends on nothing; imported by every module under rtl/core except hbs_grid_mem
package hbs_pkg;

  // fixed field widths
  localparam int COORD_W    = 24;
  localparam int COORD_FRAC = 24;
  localparam int PPB_W      = 24;
  localparam int DIM_REG_W  = 11;
  localparam int SEA_W      = 16;
  localparam int CELL_W     = 10;
  localparam int HEIGHT_W   = 16;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = COORD_W + PPB_W + 1;

  // parameter defaults
  localparam int DEF_MAX_DIM   = 1024;
  localparam int DEF_FRAC_BITS = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PPB      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEA      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_PRES = 3'd4;

  // register reset values
  localparam logic [PPB_W-1:0]     RST_PPB    = 24'd16384;
  localparam logic [DIM_REG_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [DIM_REG_W-1:0] RST_HEIGHT = 11'd1024;
  localparam logic [SEA_W-1:0]     RST_SEA    = 16'd16;

  // item modes
  localparam logic [1:0] MODE_WRITE    = 2'd0;
  localparam logic [1:0] MODE_NEAREST  = 2'd1;
  localparam logic [1:0] MODE_BILINEAR = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_X,
    ST_SCALE_Z,
    ST_TAKE_X,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_ROW_FAR,
    ST_MIX,
    ST_NEAR,
    ST_OUT
  } state_t;

  // one axis handed to the coordinate unit
  typedef struct packed {
    logic                      bilin;
    logic signed [COORD_W-1:0] coord;
  } coord_req_t;

  // blend datapath strobes
  typedef struct packed {
    logic take_hold;
    logic load_near;
    logic load_far;
  } blend_ctl_t;

endpackage

@@ rtl/core/hbs_grid_mem.sv @@
// hbs_grid_mem: single-ported height grid store, one access per cycle, registered read
// depends on nothing else; contents undefined until written
module hbs_grid_mem #(
  parameter int ADDR_W = 20,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/hbs_coord.sv @@
// hbs_coord: scales one world coordinate into the grid and clamps it, two stages
// depends on hbs_pkg (coord_req_t, widths)
module hbs_coord #(
  parameter int MAX_DIM   = hbs_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = hbs_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  hbs_pkg::coord_req_t                req,
  input  logic [hbs_pkg::PPB_W-1:0]          ppb,
  input  logic [$clog2(MAX_DIM)-1:0]         lim,
  output logic [$clog2(MAX_DIM)-1:0]         idx,
  output logic [FRAC_BITS-1:0]               frac
);
  import hbs_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int QW = COORD_FRAC + FRAC_BITS;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_bilin;
  logic [IW-1:0]            prod_lim;

  logic                     nonpos;
  logic [PROD_W-2:0]        rnd;
  logic [COORD_W-1:0]       near_full;
  logic [QW-1:0]            q;
  logic [IW+FRAC_BITS-1:0]  top;
  logic [IW-1:0]            idx_next;
  logic [FRAC_BITS-1:0]     frac_next;

  // stage 1: scale by pixels per block
  always_ff @(posedge clk) begin
    prod       <= $signed(req.coord) * $signed({1'b0, ppb});
    prod_bilin <= req.bilin;
    prod_lim   <= lim;
  end

  // stage 2 logic: round or truncate, then clamp into the grid
  always_comb begin
    nonpos    = prod[PROD_W-1] || (prod == '0);
    rnd       = prod[PROD_W-2:0] + (PROD_W-1)'(1 << (COORD_FRAC - 1));
    near_full = rnd[PROD_W-2:COORD_FRAC];
    q         = prod[PROD_W-2:COORD_FRAC-FRAC_BITS];
    top       = {prod_lim, {FRAC_BITS{1'b0}}} - (IW+FRAC_BITS)'(1);
    idx_next  = '0;
    frac_next = '0;
    if (nonpos) begin
      idx_next  = '0;
      frac_next = '0;
    end else if (prod_bilin) begin
      if (q > QW'(top)) begin
        idx_next  = top[IW+FRAC_BITS-1:FRAC_BITS];
        frac_next = top[FRAC_BITS-1:0];
      end else begin
        idx_next  = q[IW+FRAC_BITS-1:FRAC_BITS];
        frac_next = q[FRAC_BITS-1:0];
      end
    end else begin
      if (near_full > COORD_W'(prod_lim)) begin
        idx_next = prod_lim;
      end else begin
        idx_next = near_full[IW-1:0];
      end
    end
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    frac <= frac_next;
  end

endmodule

@@ rtl/core/hbs_blend.sv @@
// hbs_blend: row blends of the four neighbours and the final mix between rows
// depends on hbs_pkg (blend_ctl_t, widths)
module hbs_blend #(
  parameter int FRAC_BITS = hbs_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  hbs_pkg::blend_ctl_t              ctl,
  input  logic [hbs_pkg::HEIGHT_W-1:0]     rdata,
  input  logic [FRAC_BITS-1:0]             fx,
  input  logic [FRAC_BITS-1:0]             fz,
  output logic [hbs_pkg::HEIGHT_W+FRAC_BITS-1:0] mix_value
);
  import hbs_pkg::*;

  localparam int WW = FRAC_BITS + 1;
  localparam int RW = HEIGHT_W + FRAC_BITS;
  localparam int SW = HEIGHT_W + 2 * FRAC_BITS;

  logic [HEIGHT_W-1:0] hold;
  logic [RW-1:0]       near_row;
  logic [RW-1:0]       far_row;
  logic [WW-1:0]       omfx;
  logic [WW-1:0]       omfz;
  logic [RW-1:0]       row_value;
  logic [SW-1:0]       mix_sum;

  // complementary weights
  assign omfx = {1'b1, {FRAC_BITS{1'b0}}} - WW'(fx);
  assign omfz = {1'b1, {FRAC_BITS{1'b0}}} - WW'(fz);

  // blend of the held cell with the one now read
  assign row_value = RW'(hold) * RW'(omfx) + RW'(rdata) * RW'(fx);

  // blend between rows, truncated
  assign mix_sum   = SW'(near_row) * SW'(omfz) + SW'(far_row) * SW'(fz);
  assign mix_value = RW'(mix_sum >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (ctl.take_hold) begin
      hold <= rdata;
    end
    if (ctl.load_near) begin
      near_row <= row_value;
    end
    if (ctl.load_far) begin
      far_row <= row_value;
    end
  end

endmodule

@@ rtl/core/heightmap_bilinear_sampler_core.sv @@
// heightmap_bilinear_sampler_core: top level, sequencer, registers and result beat
// depends on hbs_pkg, hbs_grid_mem, hbs_coord, hbs_blend
//
// Holds a MAX_DIM x MAX_DIM grid of 16-bit heights in one single-ported memory and
// samples it at signed Q15.8 world positions scaled by pixels_per_block. A write beat
// stores one in-range cell and an unused mode is dropped; neither leaves the idle state.
// With no map present a query returns sea_level. A nearest or bilinear query holds
// off the next beat until its result is loaded for output: the two axes go through
// one shared two-stage scale and clamp unit, and the four neighbours are read one per
// cycle through the single memory port. A finished result waits in the output register
// while the next beat is accepted. The grid has no reset and no clearing pass; a cell
// that was never written reads as an arbitrary value.
module heightmap_bilinear_sampler_core #(
  parameter int MAX_DIM   = hbs_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = hbs_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_write,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         mode,
  input  logic signed [hbs_pkg::COORD_W-1:0] world_x,
  input  logic signed [hbs_pkg::COORD_W-1:0] world_z,
  input  logic [hbs_pkg::CELL_W-1:0]         cell_x,
  input  logic [hbs_pkg::CELL_W-1:0]         cell_z,
  input  logic [hbs_pkg::HEIGHT_W-1:0]       cell_value,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hbs_pkg::OUT_W-1:0]          height_q8
);
  import hbs_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;
  localparam int RW = HEIGHT_W + FRAC_BITS;

  // clamp a grid size register to [2, MAX_DIM] and give dim - 1
  function automatic logic [IW-1:0] dim_limit(input logic [DIM_REG_W-1:0] dim);
    logic [IW-1:0] lim;
    if (dim < DIM_REG_W'(2)) begin
      lim = IW'(1);
    end else if (32'(dim) > MAX_DIM) begin
      lim = IW'(MAX_DIM - 1);
    end else begin
      lim = IW'(dim - DIM_REG_W'(1));
    end
    return lim;
  endfunction

  // configuration registers
  logic [PPB_W-1:0]     ppb;
  logic [DIM_REG_W-1:0] grid_width;
  logic [DIM_REG_W-1:0] grid_height;
  logic [SEA_W-1:0]     sea_level;
  logic                 map_present;

  // sequencer
  state_t state;
  state_t state_next;
  logic   in_accept;

  // item payload
  logic signed [COORD_W-1:0] wx;
  logic signed [COORD_W-1:0] wz;
  logic                      bilin;

  // coordinates
  coord_req_t           creq;
  logic [IW-1:0]        lim_x;
  logic [IW-1:0]        lim_z;
  logic [IW-1:0]        creq_lim;
  logic [IW-1:0]        c_idx;
  logic [FRAC_BITS-1:0] c_frac;
  logic [IW-1:0]        ix;
  logic [FRAC_BITS-1:0] fx;
  logic [IW-1:0]        iz;
  logic [FRAC_BITS-1:0] fz;
  logic [IW-1:0]        ix1;
  logic [IW-1:0]        iz1;

  // memory port
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [HEIGHT_W-1:0]  mem_rdata;
  logic                 write_in_range;

  // datapath strobes
  blend_ctl_t           bctl;
  logic                 sel_z;
  logic                 take_x;
  logic                 take_z;
  logic                 load_sea;
  logic                 load_nearest;
  logic                 load_mix;
  logic                 load_out;
  logic [RW-1:0]        mix_value;
  logic [OUT_W-1:0]     res;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign lim_x = dim_limit(grid_width);
  assign lim_z = dim_limit(grid_height);
  assign ix1   = ix + IW'(1);
  assign iz1   = iz + IW'(1);

  assign write_in_range = (32'(cell_x) < MAX_DIM) && (32'(cell_z) < MAX_DIM);

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ppb         <= RST_PPB;
      grid_width  <= RST_WIDTH;
      grid_height <= RST_HEIGHT;
      sea_level   <= RST_SEA;
      map_present <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PPB:      ppb         <= cfg_data[PPB_W-1:0];
        REG_WIDTH:    grid_width  <= cfg_data[DIM_REG_W-1:0];
        REG_HEIGHT:   grid_height <= cfg_data[DIM_REG_W-1:0];
        REG_SEA:      sea_level   <= cfg_data[SEA_W-1:0];
        REG_MAP_PRES: map_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (mode == MODE_NEAREST || mode == MODE_BILINEAR)) begin
          state_next = map_present ? ST_SCALE_X : ST_OUT;
        end
      end
      ST_SCALE_X: state_next = ST_SCALE_Z;
      ST_SCALE_Z: state_next = ST_TAKE_X;
      ST_TAKE_X:  state_next = ST_RD_A;
      ST_RD_A:    state_next = bilin ? ST_RD_B : ST_NEAR;
      ST_RD_B:    state_next = ST_RD_C;
      ST_RD_C:    state_next = ST_RD_D;
      ST_RD_D:    state_next = ST_ROW_FAR;
      ST_ROW_FAR: state_next = ST_MIX;
      ST_MIX:     state_next = ST_OUT;
      ST_NEAR:    state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_we         = 1'b0;
    mem_addr       = {iz, ix};
    bctl           = '0;
    sel_z          = 1'b0;
    take_x         = 1'b0;
    take_z         = 1'b0;
    load_sea       = 1'b0;
    load_nearest   = 1'b0;
    load_mix       = 1'b0;
    load_out       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        mem_we   = in_accept && (mode == MODE_WRITE) && write_in_range;
        mem_addr = {IW'(cell_z), IW'(cell_x)};
        load_sea = in_accept && !map_present;
      end
      ST_SCALE_X: sel_z = 1'b0;
      ST_SCALE_Z: sel_z = 1'b1;
      ST_TAKE_X:  take_x = 1'b1;
      ST_RD_A: begin
        mem_addr = {c_idx, ix};
        take_z   = 1'b1;
      end
      ST_RD_B: begin
        mem_addr       = {iz, ix1};
        bctl.take_hold = 1'b1;
      end
      ST_RD_C: begin
        mem_addr       = {iz1, ix};
        bctl.load_near = 1'b1;
      end
      ST_RD_D: begin
        mem_addr       = {iz1, ix1};
        bctl.take_hold = 1'b1;
      end
      ST_ROW_FAR: bctl.load_far = 1'b1;
      ST_MIX:     load_mix = 1'b1;
      ST_NEAR:    load_nearest = 1'b1;
      ST_OUT:     load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item payload capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      wx    <= world_x;
      wz    <= world_z;
      bilin <= (mode == MODE_BILINEAR);
    end
  end

  // coordinate unit feed
  always_comb begin
    creq.bilin = bilin;
    creq.coord = sel_z ? wz : wx;
    creq_lim   = sel_z ? lim_z : lim_x;
  end

  hbs_coord #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_coord (
    .clk  (clk),
    .req  (creq),
    .ppb  (ppb),
    .lim  (creq_lim),
    .idx  (c_idx),
    .frac (c_frac)
  );

  // grid coordinates held for the reads
  always_ff @(posedge clk) begin
    if (take_x) begin
      ix <= c_idx;
      fx <= c_frac;
    end
    if (take_z) begin
      iz <= c_idx;
      fz <= c_frac;
    end
  end

  hbs_grid_mem #(
    .ADDR_W (AW),
    .DATA_W (HEIGHT_W)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (cell_value),
    .rdata (mem_rdata)
  );

  hbs_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .ctl       (bctl),
    .rdata     (mem_rdata),
    .fx        (fx),
    .fz        (fz),
    .mix_value (mix_value)
  );

  // result value
  always_ff @(posedge clk) begin
    if (load_sea) begin
      res <= OUT_W'({sea_level, {FRAC_BITS{1'b0}}});
    end else if (load_nearest) begin
      res <= OUT_W'({mem_rdata, {FRAC_BITS{1'b0}}});
    end else if (load_mix) begin
      res <= OUT_W'(mix_value);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      height_q8 <= res;
    end
  end

endmodule

@@ bench/heightmap_bilinear_sampler_core_test.sv @@
// heightmap_bilinear_sampler_core_test: self-checking bench for the height map sampler core
// depends on hbs_pkg and heightmap_bilinear_sampler_core; keeps its own grid and register copy
// and checks every height_q8 beat against a behavioural prediction
module heightmap_bilinear_sampler_core_test;
  import hbs_pkg::*;

  localparam int MAX_DIM = DEF_MAX_DIM;
  localparam int FRAC    = DEF_FRAC_BITS;
  localparam int SETTLE  = 16;
  localparam int LIMIT   = 30_000_000;

  // one input beat
  typedef struct packed {
    logic [1:0]          mode;
    logic [COORD_W-1:0]  wx;
    logic [COORD_W-1:0]  wz;
    logic [CELL_W-1:0]   cx;
    logic [CELL_W-1:0]   cz;
    logic [HEIGHT_W-1:0] value;
  } sample_beat_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                mode;
  logic signed [COORD_W-1:0] world_x;
  logic signed [COORD_W-1:0] world_z;
  logic [CELL_W-1:0]         cell_x;
  logic [CELL_W-1:0]         cell_z;
  logic [HEIGHT_W-1:0]       cell_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [OUT_W-1:0]          height_q8;

  // bench copy of the registers and the grid
  logic [PPB_W-1:0]     scale_ppb  = RST_PPB;
  logic [DIM_REG_W-1:0] width_reg  = RST_WIDTH;
  logic [DIM_REG_W-1:0] height_reg = RST_HEIGHT;
  logic [SEA_W-1:0]     sea_reg    = RST_SEA;
  logic                 map_on     = 1'b0;
  bit [HEIGHT_W-1:0]    cell_mem [int];

  // cells touched by the last predicted query
  int span_x0, span_x1, span_z0, span_z1;

  logic [OUT_W-1:0] height_due [$];
  int  fail_count = 0;
  bit  calm = 1'b0;

  // input beats accepted so far, fill writes included
  int  sent_count = 0;

  heightmap_bilinear_sampler_core i_dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #(LIMIT);
    $display("FAIL");
    $finish;
  end

  // alternate between stretches with and without idling
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  task automatic note_mismatch(input string what, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
    $display("height mismatch (%s): got %h, want %h", what, got, want);
    fail_count++;
  endtask

  // ---------------- prediction ----------------

  function automatic int unsigned eff_dim(input logic [DIM_REG_W-1:0] d);
    if (d < 2) return 2;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // grid position with COORD_FRAC fraction bits
  function automatic longint to_grid(input logic [COORD_W-1:0] w);
    return longint'($signed(w)) * longint'(scale_ppb);
  endfunction

  function automatic int nearest_cell(input longint p, input int unsigned dim);
    longint idx;
    if (p <= 0) return 0;
    idx = (p + (longint'(1) << (COORD_FRAC - 1))) >> COORD_FRAC;
    if (idx > dim - 1) idx = dim - 1;
    return int'(idx);
  endfunction

  // position in Q.FRAC, held one lsb short of the last cell
  function automatic longint bilin_pos(input longint p, input int unsigned dim);
    longint q, top;
    if (p <= 0) return 0;
    top = (longint'(dim - 1) << FRAC) - 1;
    q = p >> (COORD_FRAC - FRAC);
    if (q > top) q = top;
    return q;
  endfunction

  function automatic longint read_cell(input int x, input int z);
    if (cell_mem.exists(z * MAX_DIM + x)) return longint'(cell_mem[z * MAX_DIM + x]);
    return 0;
  endfunction

  // expected height of a query beat; also records the cells it reads
  function automatic logic [OUT_W-1:0] sample_height(input sample_beat_t b);
    longint qx, qz, fx, fz, near_row, far_row, res;
    longint a, bb, c, d;
    longint one;
    one = longint'(1) << FRAC;
    if (b.mode == MODE_NEAREST) begin
      span_x0 = nearest_cell(to_grid(b.wx), eff_dim(width_reg));
      span_z0 = nearest_cell(to_grid(b.wz), eff_dim(height_reg));
      span_x1 = span_x0;
      span_z1 = span_z0;
      res = read_cell(span_x0, span_z0) << FRAC;
    end else begin
      qx = bilin_pos(to_grid(b.wx), eff_dim(width_reg));
      qz = bilin_pos(to_grid(b.wz), eff_dim(height_reg));
      span_x0 = int'(qx >> FRAC);
      span_z0 = int'(qz >> FRAC);
      span_x1 = span_x0 + 1;
      span_z1 = span_z0 + 1;
      fx = qx & (one - 1);
      fz = qz & (one - 1);
      a  = read_cell(span_x0, span_z0);
      bb = read_cell(span_x1, span_z0);
      c  = read_cell(span_x0, span_z1);
      d  = read_cell(span_x1, span_z1);
      near_row = a * (one - fx) + bb * fx;
      far_row  = c * (one - fx) + d * fx;
      res = (near_row * (one - fz) + far_row * fz) >> FRAC;
    end
    if (!map_on) res = longint'(sea_reg) << FRAC;
    return OUT_W'(res);
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HEIGHT_W'($urandom);
  endfunction

  function automatic sample_beat_t random_beat();
    sample_beat_t b;
    b.mode  = 2'($urandom);
    b.wx    = COORD_W'($urandom);
    b.wz    = COORD_W'($urandom);
    b.cx    = CELL_W'($urandom);
    b.cz    = CELL_W'($urandom);
    b.value = HEIGHT_W'($urandom);
    return b;
  endfunction

  // world coordinate aimed mostly at the grid under the current scale
  function automatic logic [COORD_W-1:0] aim_world(input int unsigned dim);
    longint reach;
    int unsigned r;
    logic [COORD_W-1:0] v;
    if (scale_ppb == 0) reach = 8388607;
    else reach = (longint'(dim + 1) << COORD_FRAC) / longint'(scale_ppb);
    if (reach > 8388607) reach = 8388607;
    r = $urandom_range(0, 19);
    if (r == 0) v = COORD_W'($urandom);
    else if (r == 1) v = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    else if (r < 4) v = -COORD_W'($urandom_range(0, int'(reach) / 4));
    else v = COORD_W'($urandom_range(0, int'(reach)));
    return v;
  endfunction

  // send one beat and queue its expected height once accepted
  task automatic issue_beat(input sample_beat_t b);
    int gap;
    bit has_due;
    logic [OUT_W-1:0] due;
    has_due = 1'b0;
    due = '0;
    if (b.mode == MODE_WRITE) begin
      cell_mem[int'(b.cz) * MAX_DIM + int'(b.cx)] = b.value;
    end else if (b.mode != MODE_UNUSED) begin
      has_due = 1'b1;
      due = sample_height(b);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= b.mode;
    world_x    <= b.wx;
    world_z    <= b.wz;
    cell_x     <= b.cx;
    cell_z     <= b.cz;
    cell_value <= b.value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sent_count++;
    if (has_due) height_due.push_back(due);
  endtask

  task automatic issue_write(input int x, input int z, input logic [HEIGHT_W-1:0] v);
    sample_beat_t b;
    b = random_beat();
    b.mode  = MODE_WRITE;
    b.cx    = CELL_W'(x);
    b.cz    = CELL_W'(z);
    b.value = v;
    issue_beat(b);
  endtask

  // a query; any cell it would read that holds nothing yet is written first
  task automatic issue_query(input logic [1:0] m, input logic [COORD_W-1:0] wx,
                             input logic [COORD_W-1:0] wz);
    sample_beat_t b;
    int xs [2];
    int zs [2];
    b = random_beat();
    b.mode = m;
    b.wx = wx;
    b.wz = wz;
    if (map_on) begin
      void'(sample_height(b));
      xs[0] = span_x0;
      xs[1] = span_x1;
      zs[0] = span_z0;
      zs[1] = span_z1;
      foreach (zs[j]) begin
        foreach (xs[k]) begin
          if (!cell_mem.exists(zs[j] * MAX_DIM + xs[k]))
            issue_write(xs[k], zs[j], pick_height());
        end
      end
    end
    issue_beat(b);
  endtask

  // let every outstanding result drain and the block fall idle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (height_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  // write all five registers back to back while the block is idle
  task automatic load_settings(input logic [PPB_W-1:0] ppb, input logic [DIM_REG_W-1:0] w,
                               input logic [DIM_REG_W-1:0] h, input logic [SEA_W-1:0] sea,
                               input logic present);
    quiesce();
    put_reg(REG_PPB, CFG_DATA_W'(ppb));
    put_reg(REG_WIDTH, CFG_DATA_W'(w));
    put_reg(REG_HEIGHT, CFG_DATA_W'(h));
    put_reg(REG_SEA, CFG_DATA_W'(sea));
    put_reg(REG_MAP_PRES, CFG_DATA_W'(present));
    cfg_write <= 1'b0;
    scale_ppb  = ppb;
    width_reg  = w;
    height_reg = h;
    sea_reg    = sea;
    map_on     = present;
  endtask

  // random mix of writes, queries and dropped beats under the current settings,
  // counted in accepted beats, fill writes included
  task automatic run_traffic(input int count);
    int start;
    int unsigned r;
    sample_beat_t b;
    start = sent_count;
    while (sent_count - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        b = random_beat();
        b.mode = MODE_UNUSED;
        issue_beat(b);
      end else if (r < 12) begin
        issue_write(int'($urandom_range(0, MAX_DIM - 1)),
                    int'($urandom_range(0, MAX_DIM - 1)), pick_height());
      end else if (r < 20) begin
        issue_write(int'($urandom_range(0, eff_dim(width_reg) - 1)),
                    int'($urandom_range(0, eff_dim(height_reg) - 1)), pick_height());
      end else if (r < 58) begin
        issue_query(MODE_NEAREST, aim_world(eff_dim(width_reg)),
                    aim_world(eff_dim(height_reg)));
      end else begin
        issue_query(MODE_BILINEAR, aim_world(eff_dim(width_reg)),
                    aim_world(eff_dim(height_reg)));
      end
    end
  endtask

  function automatic logic [PPB_W-1:0] random_scale();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'd1;
    if (r == 1) return 24'hFFFFFF;
    if (r == 2) return 24'd0;
    if (r < 5) return PPB_W'($urandom);
    return PPB_W'($urandom_range(4096, 1 << 20));
  endfunction

  function automatic logic [DIM_REG_W-1:0] random_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return DIM_REG_W'($urandom_range(0, 1));
    if (r == 1) return DIM_REG_W'($urandom_range(MAX_DIM + 1, 2047));
    if (r == 2) return DIM_REG_W'($urandom_range(2, MAX_DIM));
    return DIM_REG_W'($urandom_range(2, 12));
  endfunction

  // ---------------- tests ----------------

  // no map loaded: every query answers sea level, first with reset settings
  task automatic test_sea_level();
    sample_beat_t b;
    issue_query(MODE_NEAREST, COORD_W'($urandom), COORD_W'($urandom));
    issue_query(MODE_BILINEAR, 24'h7FFFFF, 24'h800000);
    b = random_beat();
    b.mode = MODE_UNUSED;
    issue_beat(b);
    issue_write(MAX_DIM - 1, MAX_DIM - 1, 16'hFFFF);
    issue_write(0, 0, 16'h0000);
    load_settings(RST_PPB, RST_WIDTH, RST_HEIGHT, 16'hFFFF, 1'b0);
    issue_query(MODE_NEAREST, 24'h000100, 24'hFFFF00);
    load_settings(RST_PPB, RST_WIDTH, RST_HEIGHT, 16'h0000, 1'b0);
    issue_query(MODE_BILINEAR, 24'h000180, 24'h000080);
  endtask

  // rounding, clamping, zero scale and grid size limits at one cell per block
  task automatic test_map_corners();
    sample_beat_t b;
    load_settings(24'd65536, 11'd4, 11'd3, 16'd777, 1'b1);
    issue_write(0, 0, 16'hFFFF);
    issue_write(1, 0, 16'h0000);
    issue_query(MODE_NEAREST, 24'h000000, 24'h000000);
    // half a cell rounds away from zero, just under half rounds down
    issue_query(MODE_NEAREST, 24'h000080, 24'h00007F);
    issue_query(MODE_NEAREST, 24'hFFFFFF, 24'h800000);
    issue_query(MODE_NEAREST, 24'h7FFFFF, 24'h7FFFFF);
    issue_query(MODE_BILINEAR, 24'h000180, 24'h0000C0);
    issue_query(MODE_BILINEAR, 24'hFFFF00, 24'h0001FF);
    issue_query(MODE_BILINEAR, 24'h7FFFFF, 24'h7FFFFF);
    // exactly on the upper clamp of a 4 x 3 grid
    issue_query(MODE_BILINEAR, 24'h0002FF, 24'h0001FF);
    b = random_beat();
    b.mode = MODE_UNUSED;
    issue_beat(b);
    // zero scale lands every position on the origin
    load_settings(24'd0, 11'd4, 11'd3, 16'd777, 1'b1);
    issue_query(MODE_NEAREST, COORD_W'($urandom), COORD_W'($urandom));
    issue_query(MODE_BILINEAR, 24'h7FFFFF, 24'h7FFFFF);
    // sizes below 2 and above the store limit
    load_settings(24'd65536, 11'd0, 11'd2047, 16'd777, 1'b1);
    issue_query(MODE_NEAREST, 24'h7FFFFF, 24'h7FFFFF);
    issue_query(MODE_BILINEAR, 24'h7FFFFF, 24'h7FFFFF);
    issue_query(MODE_BILINEAR, 24'h000080, 24'h03FF40);
  endtask

  task automatic test_scale_extremes();
    load_settings(24'd1, 11'd8, 11'd8, 16'd100, 1'b1);
    run_traffic(150);
    load_settings(24'hFFFFFF, 11'd16, 11'd16, 16'd100, 1'b1);
    run_traffic(150);
  endtask

  task automatic test_grid_size_limits();
    load_settings(24'd65536, 11'd1, 11'd0, 16'd5, 1'b1);
    run_traffic(150);
    load_settings(24'd4096, 11'd1024, 11'd2, 16'd5, 1'b1);
    run_traffic(150);
    load_settings(24'd40000, 11'd2047, 11'd1500, 16'd5, 1'b1);
    run_traffic(150);
  endtask

  task automatic test_random_settings();
    for (int i = 0; i < 6; i++) begin
      load_settings(random_scale(), random_dim(), random_dim(), SEA_W'($urandom),
                    $urandom_range(0, 4) != 0);
      run_traffic(150);
    end
  endtask

  // ---------------- result checking ----------------

  initial begin : check_heights
    logic [OUT_W-1:0] want;
    int stall_run;
    int unsigned r;
    stall_run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      // beat taken at this edge
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (height_due.size() == 0) begin
          note_mismatch("no beat pending", height_q8, '0);
        end else begin
          want = height_due.pop_front();
          if (height_q8 !== want) note_mismatch("height_q8", height_q8, want);
        end
      end
      // stall for the next cycle
      if (stall_run > 0) begin
        stall_run--;
      end else if (!calm) begin
        r = $urandom_range(0, 99);
        if (r < 3) stall_run = $urandom_range(10, 40);
        else if (r < 25) stall_run = $urandom_range(1, 3);
      end
      out_stall <= (stall_run > 0);
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    mode       <= MODE_WRITE;
    world_x    <= '0;
    world_z    <= '0;
    cell_x     <= '0;
    cell_z     <= '0;
    cell_value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sea_level();
    test_map_corners();
    test_scale_extremes();
    test_grid_size_limits();
    test_random_settings();
    quiesce();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/hbs_pkg.sv
rtl/core/hbs_grid_mem.sv
rtl/core/hbs_coord.sv
rtl/core/hbs_blend.sv
rtl/core/heightmap_bilinear_sampler_core.sv
bench/heightmap_bilinear_sampler_core_test.sv
